// ===== rtl/vlt_pkg.sv =====
// video line timing: shared constants, register indexes and stream payload layout
// used by the top level and by its port checker; no dependencies
`default_nettype none

package vlt_pkg;

  localparam int DOT_W   = 12;
  localparam int LINE_W  = 8;
  localparam int ELAP_W  = 10;
  localparam int CFG_W   = 8;
  localparam int IN_W    = 16;
  localparam int RES_W   = 24;

  localparam logic [DOT_W-1:0]  DRAW_END    = DOT_W'(960);
  localparam logic [DOT_W-1:0]  LINE_END    = DOT_W'(1232);
  localparam logic [LINE_W-1:0] VBLANK_LINE = LINE_W'(160);
  localparam logic [LINE_W-1:0] FRAME_LINES = LINE_W'(228);

  typedef enum logic [1:0] {
    REG_LINE_IRQ_EN   = 2'd0,
    REG_LINE_COMPARE  = 2'd1,
    REG_VBLANK_IRQ_EN = 2'd2,
    REG_HBLANK_IRQ_EN = 2'd3
  } reg_index_t;

  // last field in the lowest bits
  typedef struct packed {
    logic [6:0]        pad;
    logic              draw_buffer;
    logic              line_start;
    logic              hblank_dma;
    logic              vblank_dma;
    logic              hblank_irq;
    logic              vblank_irq;
    logic              line_match_irq;
    logic              in_vblank;
    logic              in_hblank;
    logic [LINE_W-1:0] line_now;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/video_line_timing_top.sv =====
// video line timing: dot and line counters with blank flags, dma and irq pulses
// depends on vlt_pkg
`default_nettype none

// Takes one request per cycle while the output is not stalled, each carrying the cycles
// elapsed since the last one, adds it to the dot counter and returns one result giving the
// line, the blank flags, the frame buffer index and the pulses raised by that step.
// Sustained rate is one request per clock while m_tready holds: a request is
// held in the input register, the counter update is combinational into the result
// register, so the result is offered once the request has passed both registers,
// and the counter state feeds back on each accepted step. Each register holds one entry:
// while a result waits, the input register still takes one request, and once
// both are full s_tready follows m_tready.
module video_line_timing_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // s_tdata: [9:0] elapsed_cycles
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [vlt_pkg::IN_W-1:0]  s_tdata,
  // m_tdata: [7:0] line_now, [8] in_hblank, [9] in_vblank, [10] line_match_irq,
  // [11] vblank_irq, [12] hblank_irq, [13] vblank_dma, [14] hblank_dma,
  // [15] line_start, [16] draw_buffer
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [vlt_pkg::RES_W-1:0]      m_tdata,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [vlt_pkg::CFG_W-1:0] cfg_data
);
  import vlt_pkg::*;

  logic              line_irq_en;
  logic [LINE_W-1:0] line_compare;
  logic              vblank_irq_en;
  logic              hblank_irq_en;

  logic              in_valid;
  logic [ELAP_W-1:0] in_elapsed;

  logic [DOT_W-1:0]  dot_count, dot_count_next;
  logic [LINE_W-1:0] line_count, line_count_next;
  logic              hblank_active, hblank_active_next;
  logic              vblank_active, vblank_active_next;
  logic              buffer_index, buffer_index_next;

  result_t           res, res_next;
  logic              res_valid;
  logic              advance;
  logic [DOT_W-1:0]  dot_sum;
  logic [LINE_W-1:0] line_inc;
  logic              wrap_line;

  assign advance  = !res_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign m_tvalid = res_valid;
  assign m_tdata  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_irq_en   <= 1'b0;
      line_compare  <= '0;
      vblank_irq_en <= 1'b0;
      hblank_irq_en <= 1'b0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_LINE_IRQ_EN:   line_irq_en   <= cfg_data[0];
        REG_LINE_COMPARE:  line_compare  <= cfg_data[LINE_W-1:0];
        REG_VBLANK_IRQ_EN: vblank_irq_en <= cfg_data[0];
        REG_HBLANK_IRQ_EN: hblank_irq_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_elapsed <= s_tdata[ELAP_W-1:0];
    end
  end

  always_comb begin
    dot_sum   = dot_count + DOT_W'(in_elapsed);
    wrap_line = dot_sum > LINE_END;
    line_inc  = line_count + LINE_W'(1);

    dot_count_next     = wrap_line ? dot_sum - LINE_END : dot_sum;
    line_count_next    = wrap_line ? line_inc : line_count;
    hblank_active_next = hblank_active;
    vblank_active_next = vblank_active;
    buffer_index_next  = buffer_index;

    res_next                = '0;
    res_next.line_match_irq = line_irq_en && (line_compare == line_count);

    if (line_count >= VBLANK_LINE) begin
      if (!vblank_active) begin
        vblank_active_next  = 1'b1;
        res_next.vblank_irq = vblank_irq_en;
        res_next.vblank_dma = 1'b1;
      end
      hblank_active_next = dot_sum > DRAW_END;
      // frame wrap looks at the line after this step's advance
      if (line_count_next >= FRAME_LINES) begin
        line_count_next    = '0;
        vblank_active_next = 1'b0;
        buffer_index_next  = !buffer_index;
      end
    end else if (dot_sum <= DRAW_END) begin
      if (hblank_active) begin
        hblank_active_next  = 1'b0;
        res_next.line_start = 1'b1;
      end
    end else begin
      if (!hblank_active) begin
        hblank_active_next  = 1'b1;
        res_next.hblank_dma = 1'b1;
        res_next.hblank_irq = hblank_irq_en;
      end
    end

    res_next.line_now    = line_count_next;
    res_next.in_hblank   = hblank_active_next;
    res_next.in_vblank   = vblank_active_next;
    res_next.draw_buffer = buffer_index_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_count     <= '0;
      line_count    <= '0;
      hblank_active <= 1'b0;
      vblank_active <= 1'b0;
      buffer_index  <= 1'b0;
      res_valid     <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid;
      if (in_valid) begin
        dot_count     <= dot_count_next;
        line_count    <= line_count_next;
        hblank_active <= hblank_active_next;
        vblank_active <= vblank_active_next;
        buffer_index  <= buffer_index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vlt_checker.sv =====
// video line timing: port-level checker and its bind to the top level
// depends on vlt_pkg and video_line_timing_top
`default_nettype none

module vlt_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [vlt_pkg::RES_W-1:0] m_tdata
);
  import vlt_pkg::*;

  result_t r;
  assign r = m_tdata;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // line counter wraps before reaching the frame length
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> r.line_now < FRAME_LINES)
    else $error("line out of range");

  // line start only leaves h-blank in a visible line
  a_line_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.line_start |-> !r.in_hblank && r.line_now < VBLANK_LINE)
    else $error("line start in wrong place");

  // interrupt requests come with their dma pulse, and an h-blank dma pulse comes with in_hblank
  a_irq_dma: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!r.hblank_irq || r.hblank_dma) && (!r.vblank_irq || r.vblank_dma)
                 && (!r.hblank_dma || r.in_hblank))
    else $error("irq without matching dma pulse");

  // nothing leaves right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind video_line_timing_top vlt_checker u_vlt_checker (.*);

`default_nettype wire

// ===== tb/video_line_timing_top_test.sv =====
// self-checking bench for video_line_timing_top: random and directed requests of elapsed
// cycles, with a bit-accurate timing predictor scored against every result
// depends on vlt_pkg and video_line_timing_top
`default_nettype none

module video_line_timing_top_test;
  import vlt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 175;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [RES_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  video_line_timing_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // pending requests and predicted results
  logic [ELAP_W-1:0] elapsed_q[$];
  result_t timing_expect_q[$];

  // predictor copy of the registers and timing state
  logic line_irq_en_m = 1'b0;
  logic [LINE_W-1:0] line_cmp_m = '0;
  logic vblank_irq_en_m = 1'b0;
  logic hblank_irq_en_m = 1'b0;
  logic [DOT_W-1:0] dot_m = '0;
  logic [LINE_W-1:0] line_m = '0;
  logic hblank_m = 1'b0;
  logic vblank_m = 1'b0;
  logic buffer_m = 1'b0;

  int errors = 0;
  int sent_count = 0;
  int got_count = 0;
  int hold_left = 0;
  bit held = 1'b0;
  int cycles = 0;

  function automatic result_t advance_timing(input logic [ELAP_W-1:0] elapsed);
    result_t r;
    r = '0;
    dot_m = dot_m + DOT_W'(elapsed);
    // compare uses the line before any advance in this step
    r.line_match_irq = line_irq_en_m && (line_cmp_m == line_m);
    if (line_m >= VBLANK_LINE) begin
      if (!vblank_m) begin
        vblank_m = 1'b1;
        r.vblank_irq = vblank_irq_en_m;
        r.vblank_dma = 1'b1;
      end
      if (dot_m <= DRAW_END) begin
        hblank_m = 1'b0;
      end else begin
        hblank_m = 1'b1;
        if (dot_m > LINE_END) begin
          dot_m = dot_m - LINE_END;
          line_m = line_m + LINE_W'(1);
        end
      end
      if (line_m >= FRAME_LINES) begin
        line_m = '0;
        vblank_m = 1'b0;
        buffer_m = ~buffer_m;
      end
    end else if (dot_m <= DRAW_END) begin
      if (hblank_m) begin
        hblank_m = 1'b0;
        r.line_start = 1'b1;
      end
    end else begin
      if (!hblank_m) begin
        hblank_m = 1'b1;
        r.hblank_dma = 1'b1;
        r.hblank_irq = hblank_irq_en_m;
      end
      if (dot_m > LINE_END) begin
        dot_m = dot_m - LINE_END;
        line_m = line_m + LINE_W'(1);
      end
    end
    r.line_now = line_m;
    r.in_hblank = hblank_m;
    r.in_vblank = vblank_m;
    r.draw_buffer = buffer_m;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
    end
  endtask

  // sender: holds a request until taken, idles at random outside the calm stretch
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        timing_expect_q.push_back(advance_timing(s_tdata[ELAP_W-1:0]));
        sent_count++;
      end
      if (!s_tvalid || s_tready) begin
        if (elapsed_q.size() > 0 &&
            ((sent_count >= 250 && sent_count < 400) || $urandom_range(0, 99) >= 35)) begin
          s_tvalid <= 1'b1;
          s_tdata <= IN_W'(elapsed_q.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: scores each result, stalls at random and once for a long hold-off
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen = result_t'(m_tdata);
        got_count++;
        if (timing_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        end else begin
          want = timing_expect_q.pop_front();
          check_field("line_now", int'(want.line_now), int'(seen.line_now));
          check_field("in_hblank", int'(want.in_hblank), int'(seen.in_hblank));
          check_field("in_vblank", int'(want.in_vblank), int'(seen.in_vblank));
          check_field("line_match_irq", int'(want.line_match_irq),
                      int'(seen.line_match_irq));
          check_field("vblank_irq", int'(want.vblank_irq), int'(seen.vblank_irq));
          check_field("hblank_irq", int'(want.hblank_irq), int'(seen.hblank_irq));
          check_field("vblank_dma", int'(want.vblank_dma), int'(seen.vblank_dma));
          check_field("hblank_dma", int'(want.hblank_dma), int'(seen.hblank_dma));
          check_field("line_start", int'(want.line_start), int'(seen.line_start));
          check_field("draw_buffer", int'(want.draw_buffer), int'(seen.draw_buffer));
        end
      end
      if (!held && got_count >= 500) begin
        held = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (got_count >= 250 && got_count < 400) || $urandom_range(0, 99) >= 35;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("video_line_timing_top_test NOT OK");
      $finish;
    end
  end

  task automatic drain;
    while (elapsed_q.size() != 0 || s_tvalid || timing_expect_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_LINE_IRQ_EN:   line_irq_en_m <= val[0];
      REG_LINE_COMPARE:  line_cmp_m <= val;
      REG_VBLANK_IRQ_EN: vblank_irq_en_m <= val[0];
      REG_HBLANK_IRQ_EN: hblank_irq_en_m <= val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // only called with the block idle
  task automatic set_config(input logic line_en, input logic [CFG_W-1:0] cmp,
                            input logic vblank_en, input logic hblank_en);
    drain();
    write_reg(REG_LINE_IRQ_EN, CFG_W'(line_en));
    write_reg(REG_LINE_COMPARE, cmp);
    write_reg(REG_VBLANK_IRQ_EN, CFG_W'(vblank_en));
    write_reg(REG_HBLANK_IRQ_EN, CFG_W'(hblank_en));
    cfg_we <= 1'b0;
  endtask

  task automatic push_random(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      // mostly long steps so the run crosses several frames
      if (pick < 65)
        elapsed_q.push_back(ELAP_W'($urandom_range(900, 1023)));
      else if (pick < 85)
        elapsed_q.push_back(ELAP_W'($urandom_range(0, 1023)));
      else
        elapsed_q.push_back(ELAP_W'($urandom_range(0, 40)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_config(1'b1, 8'd0, 1'b1, 1'b1);
    // first line gets no line start, exact draw end, h-blank entry, wrap at line end,
    // then steps that cross h-blank and the line end together
    elapsed_q.push_back(10'd0);
    elapsed_q.push_back(10'd0);
    elapsed_q.push_back(10'd960);
    elapsed_q.push_back(10'd1);
    elapsed_q.push_back(10'd0);
    elapsed_q.push_back(10'd271);
    elapsed_q.push_back(10'd1);
    elapsed_q.push_back(10'd0);
    elapsed_q.push_back(10'd1023);
    elapsed_q.push_back(10'd1023);
    elapsed_q.push_back(10'd0);
    elapsed_q.push_back(10'd500);
    elapsed_q.push_back(10'd1023);
    elapsed_q.push_back(10'd1023);
    elapsed_q.push_back(10'd682);
    elapsed_q.push_back(10'd341);

    set_config(1'b1, 8'd255, 1'b0, 1'b0);
    push_random(RANDOM_ITEMS);
    set_config(1'b1, 8'd160, 1'b1, 1'b0);
    push_random(RANDOM_ITEMS);
    set_config(1'b0, 8'd227, 1'b0, 1'b1);
    push_random(RANDOM_ITEMS);
    set_config(1'b1, CFG_W'($urandom_range(0, 227)), 1'b1, 1'b1);
    push_random(RANDOM_ITEMS);

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("video_line_timing_top_test OK");
    else
      $display("video_line_timing_top_test NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
